/* rtl/itp_pkg.sv */
package itp_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic               digits_valid;
        logic [4:0]         radix_used;
    } out_item_t;

    // Classified byte handed from front to back
    typedef struct packed {
        logic       is_digit;
        logic       set_neg;
        logic       last;
        logic [4:0] radix;
        logic [7:0] dval;
        logic       dok;
    } cmd_t;

    typedef enum logic [3:0] {
        PH_SIGN   = 4'b0001,
        PH_PREFIX = 4'b0010,
        PH_RADIX  = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    localparam logic [4:0] RADIX_BIN = 5'd2;
    localparam logic [4:0] RADIX_OCT = 5'd8;
    localparam logic [4:0] RADIX_DEC = 5'd10;
    localparam logic [4:0] RADIX_HEX = 5'd16;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;

    localparam logic [4:0] IDX_MASK = 5'h1F;
    localparam logic [7:0] NOT_DIGIT = 8'hFF;

    localparam logic [7:0] DIGIT_TABLE [0:31] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h09, NOT_DIGIT, NOT_DIGIT, NOT_DIGIT, NOT_DIGIT, NOT_DIGIT, NOT_DIGIT,
        NOT_DIGIT, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, NOT_DIGIT,
        NOT_DIGIT, NOT_DIGIT, NOT_DIGIT, NOT_DIGIT,
        NOT_DIGIT, NOT_DIGIT, NOT_DIGIT, NOT_DIGIT
    };

endpackage

/* rtl/itp_front.sv */
module itp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  itp_pkg::in_item_t in_item,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output itp_pkg::cmd_t    cmd
);

    itp_pkg::phase_t phase_reg, phase_next;
    logic [4:0]      radix_reg, radix_next;

    logic [7:0]      c;
    itp_pkg::phase_t ph;
    logic [4:0]      rad;
    logic            used;
    logic            neg;
    logic [7:0]      dval;
    logic            range_ok;

    assign c = in_item.char_byte;

    always_comb
    begin
        ph   = phase_reg;
        rad  = radix_reg;
        used = 1'b0;
        neg  = 1'b0;
        if (ph == itp_pkg::PH_SIGN)
        begin
            if (c == itp_pkg::CH_MINUS)
            begin
                neg  = 1'b1;
                used = 1'b1;
            end
            else if (c == itp_pkg::CH_PLUS)
            begin
                used = 1'b1;
            end
            ph = itp_pkg::PH_PREFIX;
        end
        if (!used && ph == itp_pkg::PH_PREFIX)
        begin
            if (c == itp_pkg::CH_ZERO)
            begin
                rad  = itp_pkg::RADIX_OCT;
                ph   = itp_pkg::PH_RADIX;
                used = 1'b1;
            end
            else
            begin
                ph = itp_pkg::PH_DIGITS;
            end
        end
        if (!used && ph == itp_pkg::PH_RADIX)
        begin
            if (c == itp_pkg::CH_X)
            begin
                rad  = itp_pkg::RADIX_HEX;
                used = 1'b1;
            end
            else if (c == itp_pkg::CH_B)
            begin
                rad  = itp_pkg::RADIX_BIN;
                used = 1'b1;
            end
            ph = itp_pkg::PH_DIGITS;
        end
    end

    assign dval     = itp_pkg::DIGIT_TABLE[5'(c - itp_pkg::CH_ZERO) & itp_pkg::IDX_MASK];
    assign range_ok = (c[7:3] == 5'h06) || (c[7:3] == 5'h07) ||
                      (c[7:3] == 5'h08) || (c[7:3] == 5'h0C);

    assign cmd.is_digit = !used;
    assign cmd.set_neg  = neg;
    assign cmd.last     = in_item.is_last;
    assign cmd.radix    = rad;
    assign cmd.dval     = dval;
    assign cmd.dok      = range_ok && (dval < {3'b000, rad});

    assign cmd_valid = in_valid;
    assign in_ready  = cmd_ready;

    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        if (in_valid && cmd_ready)
        begin
            phase_next = in_item.is_last ? itp_pkg::PH_SIGN : ph;
            radix_next = in_item.is_last ? itp_pkg::RADIX_DEC : rad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= itp_pkg::PH_SIGN;
            radix_reg <= itp_pkg::RADIX_DEC;
        end
        else
        begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
        end
    end

endmodule

/* rtl/itp_fifo.sv */
module itp_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  itp_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output itp_pkg::cmd_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    itp_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/itp_back.sv */
module itp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  itp_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output itp_pkg::out_item_t out_item
);

    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        ok_reg, ok_next;
    logic        seen_reg, seen_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_acc_reg;
    logic        out_neg_reg;
    logic        out_dv_reg;
    logic [4:0]  out_radix_reg;

    logic [63:0] scaled;
    logic [63:0] acc_upd;
    logic        neg_upd, ok_upd, seen_upd;
    logic        pop;

    assign cmd_ready = !out_valid_reg || out_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        unique case (cmd.radix)
            itp_pkg::RADIX_BIN: scaled = {acc_reg[62:0], 1'b0};
            itp_pkg::RADIX_OCT: scaled = {acc_reg[60:0], 3'b000};
            itp_pkg::RADIX_HEX: scaled = {acc_reg[59:0], 4'b0000};
            default:            scaled = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0};
        endcase
    end

    always_comb
    begin
        acc_upd  = acc_reg;
        ok_upd   = ok_reg;
        seen_upd = seen_reg;
        neg_upd  = neg_reg || cmd.set_neg;
        if (cmd.is_digit)
        begin
            acc_upd  = scaled + {56'd0, cmd.dval};
            seen_upd = 1'b1;
            ok_upd   = ok_reg && cmd.dok;
        end
    end

    always_comb
    begin
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        ok_next        = ok_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (pop)
        begin
            if (cmd.last)
            begin
                acc_next       = '0;
                neg_next       = 1'b0;
                ok_next        = 1'b1;
                seen_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                acc_next  = acc_upd;
                neg_next  = neg_upd;
                ok_next   = ok_upd;
                seen_next = seen_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && cmd.last)
        begin
            out_acc_reg   <= acc_upd;
            out_neg_reg   <= neg_upd;
            out_dv_reg    <= seen_upd && ok_upd;
            out_radix_reg <= cmd.radix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            ok_reg        <= 1'b1;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            ok_reg        <= ok_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid             = out_valid_reg;
    assign out_item.value        = $signed(out_neg_reg ? (64'd0 - out_acc_reg) : out_acc_reg);
    assign out_item.digits_valid = out_dv_reg;
    assign out_item.radix_used   = out_radix_reg;

endmodule

/* rtl/integer_text_parser.sv */
// Streaming integer token parser.
// in channel (in_valid/in_ready/in_item): one character byte per item, is_last
//   set on the final byte of a token. An optional '-' or '+' leads; a '0'
//   then selects octal, and "0x" / "0b" select hex / binary; else decimal.
// out channel (out_valid/out_ready/out_item): one result per token, issued for
//   the item carrying is_last: value (wraps mod 2^64, negated for '-'),
//   digits_valid, radix_used.
// Throughput: one byte per clock while no result is held on out. The front
//   classifies each byte against the prefix phase; the back does one shift-add
//   of the 64-bit accumulator per byte.
// Path: a last byte is registered in the queue; the back pops it from the queue
//   and registers the result and out_valid.
// Reset: clears the prefix phase, queue and accumulator; out_valid drops.
// Stall: a held result stays stable; the queue (QUEUE_DEPTH items) keeps
//   taking bytes until full, then in_ready goes low.
module integer_text_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  itp_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output itp_pkg::out_item_t out_item
);

    logic          fq_valid, fq_ready;
    itp_pkg::cmd_t fq_cmd;
    logic          qb_valid, qb_ready;
    itp_pkg::cmd_t qb_cmd;

    itp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    itp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_cmd),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_cmd)
    );

    itp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

/* rtl/itp_checker.sv */
module itp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input itp_pkg::in_item_t  in_item,
    input logic               out_valid,
    input logic               out_ready,
    input itp_pkg::out_item_t out_item
);

    // offered byte waits unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
        else $error("in_item dropped or changed while waiting");

    // held result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_item))
        else $error("out_item changed while stalled");

    a_radix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.radix_used == itp_pkg::RADIX_BIN ||
                       out_item.radix_used == itp_pkg::RADIX_OCT ||
                       out_item.radix_used == itp_pkg::RADIX_DEC ||
                       out_item.radix_used == itp_pkg::RADIX_HEX))
        else $error("bad radix_used");

    // input backpressure comes from a full queue; the queue fills only while a result is held
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("in_ready low with no pending result");

endmodule

bind integer_text_parser itp_checker u_itp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

/* sim/integer_text_parser_tb.sv */
`timescale 1ns / 1ps

module integer_text_parser_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    itp_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    itp_pkg::out_item_t out_item;

    itp_pkg::in_item_t chars_to_send[$];
    itp_pkg::out_item_t expected_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int stall_left = 0;
    int bytes_queued = 0;
    int bytes_accepted = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    // parser state as predicted from accepted characters
    itp_pkg::phase_t p_phase = itp_pkg::PH_SIGN;
    logic [4:0] p_radix = itp_pkg::RADIX_DEC;
    logic [63:0] p_acc = '0;
    logic p_neg = 1'b0;
    logic p_ok = 1'b1;
    logic p_seen = 1'b0;

    integer_text_parser dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item(out_item)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [4:0] idx;
        idx = 5'(c - itp_pkg::CH_ZERO);
        if (idx < 5'd10)
            return {3'b000, idx};
        else if (idx >= 5'd17 && idx <= 5'd22)
            return {3'b000, idx} - 8'd7;
        else
            return itp_pkg::NOT_DIGIT;
    endfunction

    // only 0x30..0x47 and 0x60..0x67 count as digit characters
    function automatic logic digit_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h47) || (c >= 8'h60 && c <= 8'h67);
    endfunction

    task automatic clear_parse_state();
        p_phase = itp_pkg::PH_SIGN;
        p_radix = itp_pkg::RADIX_DEC;
        p_acc = '0;
        p_neg = 1'b0;
        p_ok = 1'b1;
        p_seen = 1'b0;
    endtask

    task automatic parse_char(input itp_pkg::in_item_t it);
        logic [7:0] c;
        logic consumed;
        logic [7:0] dv;
        itp_pkg::out_item_t res;
        c = it.char_byte;
        consumed = 1'b0;
        if (p_phase == itp_pkg::PH_SIGN)
        begin
            if (c == itp_pkg::CH_MINUS)
            begin
                p_neg = 1'b1;
                consumed = 1'b1;
            end
            else if (c == itp_pkg::CH_PLUS)
            begin
                consumed = 1'b1;
            end
            p_phase = itp_pkg::PH_PREFIX;
        end
        if (!consumed && p_phase == itp_pkg::PH_PREFIX)
        begin
            if (c == itp_pkg::CH_ZERO)
            begin
                p_radix = itp_pkg::RADIX_OCT;
                p_phase = itp_pkg::PH_RADIX;
                consumed = 1'b1;
            end
            else
            begin
                p_phase = itp_pkg::PH_DIGITS;
            end
        end
        if (!consumed && p_phase == itp_pkg::PH_RADIX)
        begin
            if (c == itp_pkg::CH_X)
            begin
                p_radix = itp_pkg::RADIX_HEX;
                consumed = 1'b1;
            end
            else if (c == itp_pkg::CH_B)
            begin
                p_radix = itp_pkg::RADIX_BIN;
                consumed = 1'b1;
            end
            p_phase = itp_pkg::PH_DIGITS;
        end
        if (!consumed)
        begin
            dv = digit_value(c);
            p_acc = p_acc * {59'd0, p_radix} + {56'd0, dv};
            p_seen = 1'b1;
            if (!digit_char(c) || dv >= {3'b000, p_radix})
                p_ok = 1'b0;
        end
        if (it.is_last)
        begin
            res.value = p_neg ? 64'd0 - p_acc : p_acc;
            res.digits_valid = p_seen && p_ok;
            res.radix_used = p_radix;
            expected_results.push_back(res);
            clear_parse_state();
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_item <= chars_to_send.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            stall_left <= LONG_HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor, checker and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        itp_pkg::out_item_t exp_res;
        if (!rst_n)
        begin
            clear_parse_state();
            idle_cycles <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                bytes_accepted++;
                parse_char(in_item);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result value %0d valid %0b radix %0d",
                             $time, out_item.value, out_item.digits_valid, out_item.radix_used);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    results_checked++;
                    if (out_item.value !== exp_res.value)
                    begin
                        mismatch_count++;
                        $display("%0t: value expected %0d actual %0d",
                                 $time, exp_res.value, out_item.value);
                    end
                    if (out_item.digits_valid !== exp_res.digits_valid)
                    begin
                        mismatch_count++;
                        $display("%0t: digits_valid expected %0b actual %0b",
                                 $time, exp_res.digits_valid, out_item.digits_valid);
                    end
                    if (out_item.radix_used !== exp_res.radix_used)
                    begin
                        mismatch_count++;
                        $display("%0t: radix_used expected %0d actual %0d",
                                 $time, exp_res.radix_used, out_item.radix_used);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [7:0] c, input logic last);
        itp_pkg::in_item_t it;
        it.char_byte = c;
        it.is_last = last;
        chars_to_send.push_back(it);
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], i == s.len() - 1);
    endtask

    // mostly well-formed tokens, some with a corrupted byte, some pure noise
    task automatic push_random_token();
        logic [7:0] text[$];
        int rad;
        int ndig;
        int d;
        if ($urandom_range(99) < 80)
        begin
            case ($urandom_range(2))
                1: text.push_back(itp_pkg::CH_MINUS);
                2: text.push_back(itp_pkg::CH_PLUS);
                default: ;
            endcase
            case ($urandom_range(3))
                0: rad = 10;
                1:
                begin
                    rad = 8;
                    text.push_back(itp_pkg::CH_ZERO);
                end
                2:
                begin
                    rad = 16;
                    text.push_back(itp_pkg::CH_ZERO);
                    text.push_back(itp_pkg::CH_X);
                end
                default:
                begin
                    rad = 2;
                    text.push_back(itp_pkg::CH_ZERO);
                    text.push_back(itp_pkg::CH_B);
                end
            endcase
            ndig = ($urandom_range(9) == 0) ? $urandom_range(1, 24) : $urandom_range(0, 6);
            for (int i = 0; i < ndig; i++)
            begin
                d = $urandom_range(rad - 1);
                if (d < 10)
                    text.push_back(itp_pkg::CH_ZERO + 8'(d));
                else
                    text.push_back(($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'(d - 10));
            end
            if (text.size() != 0 && $urandom_range(9) == 0)
                text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
        end
        else
        begin
            repeat ($urandom_range(1, 5))
                text.push_back(8'($urandom_range(255)));
        end
        if (text.size() == 0)
            text.push_back(8'($urandom_range(255)));
        foreach (text[i])
            push_byte(text[i], i == text.size() - 1);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (chars_to_send.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int nbytes);
        int target;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        target = bytes_queued + nbytes;
        while (bytes_queued < target)
            push_random_token();
        wait_drained();
    endtask

    initial
    begin
        string directed[$];
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{"-", "0", "+0x", "-0b1", "0777", "9", "0xaF", "1z", "09"};
        foreach (directed[i])
            push_text(directed[i]);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        wait_drained();

        run_phase(0, 0, 375);
        run_phase(63, 0, 375);
        hold_requests++;
        run_phase(0, 63, 375);
        run_phase(25, 25, 375);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d token results from %0d characters across four flow-control phases,",
                 results_checked, bytes_accepted);
        $display("including a long output hold and full drains between phases.");
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
